// ===== rtl/core/wwdt_pkg.sv =====
// shared types and constants of the windowed watchdog timer
package wwdt_pkg;

   localparam int DATA_BITS = 24;
   localparam int WARN_BITS = 10;
   localparam int OP_BITS   = 2;
   localparam int IDX_BITS  = 3;

   // item opcodes
   localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_WRITE = 2'd2;
   localparam logic [OP_BITS-1:0] OP_NOP   = 2'd3;

   // register indexes
   localparam logic [IDX_BITS-1:0] REG_MODE    = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_RELOAD  = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_FEED    = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_COUNTER = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_WARNING = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_WINDOW  = 3'd6;

   // mode register bit positions
   localparam int MODE_ENABLE_POS   = 0;
   localparam int MODE_RST_EN_POS   = 1;
   localparam int MODE_WARN_CLR_POS = 3;

   localparam logic [DATA_BITS-1:0] FEED_FIRST   = 24'hAA;
   localparam logic [DATA_BITS-1:0] FEED_SECOND  = 24'h55;
   localparam logic [DATA_BITS-1:0] WARNING_MAX  = 24'h3FF;
   localparam logic [31:0]          RELOAD_FLOOR = 32'hFF;
   localparam logic [31:0]          WINDOW_FLOOR = 32'h100;
   localparam logic [31:0]          WINDOW_RESET = 32'hFFFFFF;

   typedef struct packed {
      logic [OP_BITS-1:0]   opcode;
      logic [IDX_BITS-1:0]  reg_index;
      logic [DATA_BITS-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] read_data;
      logic                 warning_irq;
      logic                 chip_reset;
      logic                 timeout_flag;
   } rsp_type;

endpackage

// ===== rtl/core/wwdt_if.sv =====
// request and response channel interfaces of the watchdog
interface wwdt_req_if;
   logic                            valid;
   logic                            ready;
   logic [wwdt_pkg::OP_BITS-1:0]    opcode;
   logic [wwdt_pkg::IDX_BITS-1:0]   reg_index;
   logic [wwdt_pkg::DATA_BITS-1:0]  write_data;

   modport source (output valid, output opcode, output reg_index, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input reg_index, input write_data,
                   output ready);
endinterface

interface wwdt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [wwdt_pkg::DATA_BITS-1:0]  read_data;
   logic                            warning_irq;
   logic                            chip_reset;
   logic                            timeout_flag;

   modport source (output valid, output read_data, output warning_irq,
                   output chip_reset, output timeout_flag, input ready);
   modport sink   (input valid, input read_data, input warning_irq,
                   input chip_reset, input timeout_flag, output ready);
endinterface

// ===== rtl/core/windowed_watchdog_timer.sv =====
// windowed watchdog timer: item register, register-file update, result register
// a request is captured in the item register, and its result then in the result register
// throughput: one item per cycle; the item register advances whenever the
//   result register is empty or its result transfers in the same cycle
// reset: synchronous; clears control, flags and counters to their reset values
module windowed_watchdog_timer #(
   parameter int COUNTER_BITS = 24,
   parameter int PRESCALE     = 4
) (
   input  logic       clock,
   input  logic       reset,
   wwdt_req_if.sink   req_bus,
   wwdt_rsp_if.source rsp_bus
);

   localparam int PS_BITS = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
   localparam int DB      = wwdt_pkg::DATA_BITS;
   localparam int WB      = wwdt_pkg::WARN_BITS;

   localparam logic [COUNTER_BITS-1:0] RELOAD_FLOOR_C = COUNTER_BITS'(wwdt_pkg::RELOAD_FLOOR);
   localparam logic [COUNTER_BITS-1:0] WINDOW_FLOOR_C = COUNTER_BITS'(wwdt_pkg::WINDOW_FLOOR);
   localparam logic [COUNTER_BITS-1:0] WINDOW_RESET_C = COUNTER_BITS'(wwdt_pkg::WINDOW_RESET);
   localparam logic [PS_BITS-1:0]      PS_LAST        = PS_BITS'(PRESCALE - 1);

   // item register
   logic              s1_valid_ff;
   logic              s1_valid_in;
   wwdt_pkg::req_type s1_item_ff;
   logic              s1_go;
   logic              out_ready;

   // watchdog state
   logic                    enable_ff,    enable_in;
   logic                    rst_en_ff,    rst_en_in;
   logic                    timeout_ff,   timeout_in;
   logic                    warning_ff,   warning_in;
   logic                    running_ff,   running_in;
   logic                    feed_phase_ff, feed_phase_in;
   logic [COUNTER_BITS-1:0] reload_ff,    reload_in;
   logic [COUNTER_BITS-1:0] counter_ff,   counter_in;
   logic [COUNTER_BITS-1:0] window_ff,    window_in;
   logic [WB-1:0]           warn_val_ff,  warn_val_in;
   logic [PS_BITS-1:0]      prescale_ff,  prescale_in;

   logic                    wd_event;
   logic [DB-1:0]           read_c;
   logic [COUNTER_BITS-1:0] wdata_c;
   logic [COUNTER_BITS-1:0] cnt_dec;
   wwdt_pkg::rsp_type       rsp_c;

   assign s1_go         = s1_valid_ff && out_ready;
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign s1_valid_in   = (req_bus.valid && req_bus.ready) || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_item_ff.opcode     <= req_bus.opcode;
         s1_item_ff.reg_index  <= req_bus.reg_index;
         s1_item_ff.write_data <= req_bus.write_data;
      end
   end

   assign wdata_c = COUNTER_BITS'(s1_item_ff.write_data);
   assign cnt_dec = counter_ff - 1'b1;

   always_comb begin
      enable_in     = enable_ff;
      rst_en_in     = rst_en_ff;
      warning_in    = warning_ff;
      running_in    = running_ff;
      feed_phase_in = feed_phase_ff;
      reload_in     = reload_ff;
      counter_in    = counter_ff;
      window_in     = window_ff;
      warn_val_in   = warn_val_ff;
      prescale_in   = prescale_ff;
      wd_event      = 1'b0;
      read_c        = '0;

      unique case (s1_item_ff.opcode)
         wwdt_pkg::OP_TICK: begin
            if (running_ff) begin
               if (prescale_ff == PS_LAST) begin
                  prescale_in = '0;
                  if (counter_ff != '0) begin
                     counter_in = cnt_dec;
                     if (cnt_dec == COUNTER_BITS'(warn_val_ff)) begin
                        warning_in = 1'b1;
                     end
                     if (cnt_dec == '0) begin
                        wd_event = 1'b1;
                     end
                  end
               end else begin
                  prescale_in = prescale_ff + 1'b1;
               end
            end
         end
         wwdt_pkg::OP_READ: begin
            unique case (s1_item_ff.reg_index)
               wwdt_pkg::REG_MODE:
                  read_c = DB'({warning_ff, timeout_ff, rst_en_ff, enable_ff});
               wwdt_pkg::REG_RELOAD:  read_c = DB'(reload_ff);
               wwdt_pkg::REG_COUNTER: read_c = DB'(counter_ff);
               wwdt_pkg::REG_WARNING: read_c = DB'(warn_val_ff);
               wwdt_pkg::REG_WINDOW:  read_c = DB'(window_ff);
               default:               read_c = '0;
            endcase
         end
         wwdt_pkg::OP_WRITE: begin
            if (s1_item_ff.reg_index == wwdt_pkg::REG_FEED) begin
               if (!feed_phase_ff) begin
                  if (s1_item_ff.write_data == wwdt_pkg::FEED_FIRST) begin
                     feed_phase_in = 1'b1;
                  end
               end else begin
                  feed_phase_in = 1'b0;
                  if (s1_item_ff.write_data != wwdt_pkg::FEED_SECOND) begin
                     wd_event = running_ff;
                  end else if (running_ff && (counter_ff > window_ff)) begin
                     // feed too early: outside the window
                     wd_event = 1'b1;
                  end else begin
                     counter_in = reload_ff;
                     if (enable_ff) begin
                        running_in = 1'b1;
                     end
                  end
               end
            end else begin
               // any other write breaks an open feed sequence
               if (feed_phase_ff) begin
                  feed_phase_in = 1'b0;
                  wd_event      = running_ff;
               end
               unique case (s1_item_ff.reg_index)
                  wwdt_pkg::REG_MODE: begin
                     if (s1_item_ff.write_data[wwdt_pkg::MODE_ENABLE_POS]) begin
                        enable_in = 1'b1;
                     end
                     if (s1_item_ff.write_data[wwdt_pkg::MODE_RST_EN_POS]) begin
                        rst_en_in = 1'b1;
                     end
                     if (s1_item_ff.write_data[wwdt_pkg::MODE_WARN_CLR_POS]) begin
                        warning_in = 1'b0;
                     end
                  end
                  wwdt_pkg::REG_RELOAD:
                     reload_in = (wdata_c < RELOAD_FLOOR_C) ? RELOAD_FLOOR_C : wdata_c;
                  wwdt_pkg::REG_WARNING:
                     warn_val_in = (s1_item_ff.write_data > wwdt_pkg::WARNING_MAX) ?
                                   WB'(wwdt_pkg::WARNING_MAX) : s1_item_ff.write_data[WB-1:0];
                  wwdt_pkg::REG_WINDOW:
                     window_in = (wdata_c < WINDOW_FLOOR_C) ? WINDOW_FLOOR_C : wdata_c;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase

      timeout_in = timeout_ff || wd_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         rst_en_ff     <= 1'b0;
         timeout_ff    <= 1'b0;
         warning_ff    <= 1'b0;
         running_ff    <= 1'b0;
         feed_phase_ff <= 1'b0;
         reload_ff     <= RELOAD_FLOOR_C;
         counter_ff    <= RELOAD_FLOOR_C;
         window_ff     <= WINDOW_RESET_C;
         warn_val_ff   <= '0;
         prescale_ff   <= '0;
      end else if (s1_go) begin
         enable_ff     <= enable_in;
         rst_en_ff     <= rst_en_in;
         timeout_ff    <= timeout_in;
         warning_ff    <= warning_in;
         running_ff    <= running_in;
         feed_phase_ff <= feed_phase_in;
         reload_ff     <= reload_in;
         counter_ff    <= counter_in;
         window_ff     <= window_in;
         warn_val_ff   <= warn_val_in;
         prescale_ff   <= prescale_in;
      end
   end

   // chip reset uses reset-enable as it stood before this item
   assign rsp_c.read_data    = read_c;
   assign rsp_c.warning_irq  = warning_in;
   assign rsp_c.chip_reset   = wd_event && rst_en_ff;
   assign rsp_c.timeout_flag = timeout_in;

   wwdt_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ready (out_ready),
      .in_data  (rsp_c),
      .rsp_bus  (rsp_bus)
   );

`ifndef SYNTHESIS
   a_reset_needs_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (!rsp_bus.chip_reset || rsp_bus.timeout_flag))
      else $error("chip reset without timeout flag");

   a_enable_sticky: assert property (@(posedge clock) disable iff (reset)
      enable_ff |=> enable_ff)
      else $error("enable bit cleared without reset");

   a_running_enabled: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> enable_ff)
      else $error("watchdog running while not enabled");

   a_prescale_idle: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (prescale_ff == '0))
      else $error("prescaler moved while stopped");
`endif

endmodule

// ===== rtl/core/wwdt_rsp_reg.sv =====
// result register that drives the response channel
module wwdt_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  wwdt_pkg::rsp_type in_data,
   wwdt_rsp_if.source        rsp_bus
);

   logic              valid_ff;
   logic              valid_in;
   wwdt_pkg::rsp_type data_ff;

   // take a new result when empty or when the held one transfers now
   assign in_ready = !valid_ff || rsp_bus.ready;
   assign valid_in = in_valid || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.read_data    = data_ff.read_data;
   assign rsp_bus.warning_irq  = data_ff.warning_irq;
   assign rsp_bus.chip_reset   = data_ff.chip_reset;
   assign rsp_bus.timeout_flag = data_ff.timeout_flag;

endmodule
